@@ rtl/ptsb_pkg.sv @@
// ----------------------------------------------------------------------------
// ptsb_pkg
// Shared types and constants for the periodic timer slot bank.
// ----------------------------------------------------------------------------
`default_nettype none

package ptsb_pkg;

	// Input word kinds
	typedef enum logic [1:0] {
		KIND_TICK  = 2'd0,
		KIND_ARM   = 2'd1,
		KIND_QUERY = 2'd2
	} kind_t;

	// Counter value at which wrap handling runs
	localparam logic [31:0] WRAP_POINT = 32'h0000_FFFF;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_TICK,
		ST_SW_RD,
		ST_SW_WR
	} state_t;

	// One slot entry as held in the slot memory
	typedef struct packed {
		logic [31:0] start;
		logic [31:0] deadline;
		logic [15:0] period;
	} slot_ent_t;

	// Memory controls issued by the sequencer
	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic clr_dl;
	} mem_ctl_t;

endpackage

`default_nettype wire

@@ rtl/periodic_timer_slot_bank.sv @@
// ----------------------------------------------------------------------------
// periodic_timer_slot_bank
// Bank of periodic timer slots driven by a shared tick counter.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (kind, slot, period) are taken at a clock edge where start is
//   high and busy is low. Every word yields exactly one result: done pulses
//   for one cycle with expired; the receiver cannot stall it.
//   Kinds: tick advances the counter and runs wrap handling, arm loads a
//   slot with a period, query reports and rearms an expired slot.
//   Steps per word:
//     arm / query in range : a read of the slot memory at accept, then a
//                            read-modify-write in the update state; the next
//                            word may be taken in the done cycle.
//     tick                 : done is registered from the tick state.
//     tick ending overflow : done at the end of the rebase sweep, which reads
//                            and writes back each slot in turn (read state,
//                            then write state) through the single slot memory.
//     out-of-range slot or unused kind : done is registered at accept.
//   Reset clears the counter, the wrap limit, the overflow phase and all
//   armed bits; slot start and deadline read as zero through valid bits, so
//   there is no clearing pass and the block accepts words right after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_timer_slot_bank #(
	parameter int NUM_SLOTS = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire  [1:0]  kind,
	input  wire  [3:0]  slot,
	input  wire  [15:0] period,
	output logic        done,
	output logic        expired
);

	localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	ptsb_pkg::state_t state_q, state_d;

	logic [31:0]          tick_q;
	logic [31:0]          wrap_q;
	logic                 ovf_q;
	logic [NUM_SLOTS-1:0] armed_q;

	logic [1:0]       kind_q;
	logic [15:0]      period_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] sw_idx_q;
	logic             done_q;
	logic             expired_q;

	ptsb_pkg::mem_ctl_t  ctl;
	logic [IDX_W-1:0]    rd_addr;
	logic [IDX_W-1:0]    wr_addr;
	ptsb_pkg::slot_ent_t wr_data;
	ptsb_pkg::slot_ent_t rd_ent;

	logic accept;
	logic slot_ok;
	logic mem_op;
	logic done_d;
	logic expired_d;

	// update datapath
	logic        is_arm;
	logic        hit;
	logic        rearm;
	logic [15:0] new_per;
	logic [31:0] new_dl;
	ptsb_pkg::slot_ent_t upd_ent;
	ptsb_pkg::slot_ent_t sw_ent;

	// tick datapath
	logic [31:0] tick_inc;
	logic [31:0] wrap_dec;
	logic        tick_clr;
	logic        tick_enter_ovf;
	logic        tick_rebase;
	logic        sw_last;

	assign busy    = (state_q != ptsb_pkg::ST_IDLE);
	assign accept  = start && !busy;
	assign slot_ok = ({5'd0, slot} < 9'(NUM_SLOTS));
	assign mem_op  = ((kind == ptsb_pkg::KIND_ARM) || (kind == ptsb_pkg::KIND_QUERY)) && slot_ok;
	assign done    = done_q;
	assign expired = expired_q;

	// slot update: arm, or query with possible rearm from stored period
	assign is_arm  = (kind_q == ptsb_pkg::KIND_ARM);
	assign hit     = armed_q[idx_q] && (tick_q >= rd_ent.deadline);
	assign rearm   = is_arm || hit;
	assign new_per = is_arm ? period_q : rd_ent.period;
	assign new_dl  = tick_q + {16'd0, new_per};

	always_comb begin
		upd_ent.start    = tick_q;
		upd_ent.period   = rearm ? new_per : rd_ent.period;
		upd_ent.deadline = rearm ? new_dl : rd_ent.deadline;
	end

	// rebase: deadline minus start
	always_comb begin
		sw_ent          = rd_ent;
		sw_ent.deadline = rd_ent.deadline - rd_ent.start;
	end

	assign tick_inc       = tick_q + 32'd1;
	assign wrap_dec       = wrap_q - 32'd1;
	assign tick_clr       = !ovf_q && (tick_inc >= ptsb_pkg::WRAP_POINT) && (tick_inc >= wrap_q);
	assign tick_enter_ovf = !ovf_q && (tick_inc >= ptsb_pkg::WRAP_POINT) && (tick_inc < wrap_q);
	assign tick_rebase    = ovf_q && (wrap_dec == 32'd0);
	assign sw_last        = (sw_idx_q == IDX_W'(NUM_SLOTS - 1));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ptsb_pkg::ST_IDLE: begin
				if (accept) begin
					if (kind == ptsb_pkg::KIND_TICK) begin
						state_d = ptsb_pkg::ST_TICK;
					end else if (mem_op) begin
						state_d = ptsb_pkg::ST_UPDATE;
					end
				end
			end
			ptsb_pkg::ST_UPDATE: begin
				state_d = ptsb_pkg::ST_IDLE;
			end
			ptsb_pkg::ST_TICK: begin
				state_d = tick_rebase ? ptsb_pkg::ST_SW_RD : ptsb_pkg::ST_IDLE;
			end
			ptsb_pkg::ST_SW_RD: begin
				state_d = ptsb_pkg::ST_SW_WR;
			end
			ptsb_pkg::ST_SW_WR: begin
				state_d = sw_last ? ptsb_pkg::ST_IDLE : ptsb_pkg::ST_SW_RD;
			end
			default: begin
				state_d = ptsb_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		ctl       = '0;
		rd_addr   = IDX_W'(slot);
		wr_addr   = idx_q;
		wr_data   = upd_ent;
		done_d    = 1'b0;
		expired_d = 1'b0;
		unique case (state_q)
			ptsb_pkg::ST_IDLE: begin
				if (accept && mem_op) begin
					ctl.rd_en = 1'b1;
				end else if (accept && (kind != ptsb_pkg::KIND_TICK)) begin
					done_d = 1'b1;
				end
			end
			ptsb_pkg::ST_UPDATE: begin
				ctl.wr_en = 1'b1;
				done_d    = 1'b1;
				expired_d = hit && !is_arm;
			end
			ptsb_pkg::ST_TICK: begin
				ctl.clr_dl = tick_clr;
				done_d     = !tick_rebase;
			end
			ptsb_pkg::ST_SW_RD: begin
				ctl.rd_en = 1'b1;
				rd_addr   = sw_idx_q;
			end
			ptsb_pkg::ST_SW_WR: begin
				ctl.wr_en = 1'b1;
				wr_addr   = sw_idx_q;
				wr_data   = sw_ent;
				done_d    = sw_last;
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q   <= kind;
			period_q <= period;
			idx_q    <= IDX_W'(slot);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ptsb_pkg::ST_IDLE;
			tick_q    <= '0;
			wrap_q    <= '0;
			ovf_q     <= 1'b0;
			armed_q   <= '0;
			sw_idx_q  <= '0;
			done_q    <= 1'b0;
			expired_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			done_q    <= done_d;
			expired_q <= expired_d;
			if (state_q == ptsb_pkg::ST_UPDATE && rearm) begin
				armed_q[idx_q] <= 1'b1;
				if (!ovf_q && (wrap_q <= new_dl)) begin
					wrap_q <= new_dl;
				end
			end
			if (state_q == ptsb_pkg::ST_TICK) begin
				sw_idx_q <= '0;
				if (ovf_q) begin
					wrap_q <= wrap_dec;
					if (tick_rebase) begin
						tick_q <= '0;
						ovf_q  <= 1'b0;
					end else begin
						tick_q <= tick_inc;
					end
				end else if (tick_clr) begin
					tick_q <= '0;
				end else begin
					tick_q <= tick_inc;
					if (tick_enter_ovf) begin
						ovf_q  <= 1'b1;
						wrap_q <= wrap_q - ptsb_pkg::WRAP_POINT;
					end
				end
			end
			// advance the rebase sweep
			if (state_q == ptsb_pkg::ST_SW_WR && !sw_last) begin
				sw_idx_q <= sw_idx_q + IDX_W'(1);
			end
		end
	end

	ptsb_slot_ram #(
		.NUM_SLOTS (NUM_SLOTS),
		.IDX_W     (IDX_W)
	) u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.rd_addr (rd_addr),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_data (rd_ent)
	);

endmodule

`default_nettype wire

@@ rtl/ptsb_slot_ram.sv @@
// ----------------------------------------------------------------------------
// ptsb_slot_ram
// Slot entry memory with a registered read. Per-entry valid bits make
// never-written entries read as zero start and deadline, and a separate
// deadline valid vector clears every deadline at once.
// ----------------------------------------------------------------------------
`default_nettype none

module ptsb_slot_ram #(
	parameter int NUM_SLOTS = 16,
	parameter int IDX_W     = 4
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire ptsb_pkg::mem_ctl_t  ctl,
	input  wire  [IDX_W-1:0]         rd_addr,
	input  wire  [IDX_W-1:0]         wr_addr,
	input  wire ptsb_pkg::slot_ent_t wr_data,
	output ptsb_pkg::slot_ent_t      rd_data
);

	ptsb_pkg::slot_ent_t mem_q [NUM_SLOTS];
	ptsb_pkg::slot_ent_t rd_raw_q;
	logic [NUM_SLOTS-1:0] ent_vld_q;
	logic [NUM_SLOTS-1:0] dl_vld_q;
	logic                 rd_ent_vld_q;
	logic                 rd_dl_vld_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_raw_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q    <= '0;
			dl_vld_q     <= '0;
			rd_ent_vld_q <= 1'b0;
			rd_dl_vld_q  <= 1'b0;
		end else begin
			if (ctl.wr_en) begin
				ent_vld_q[wr_addr] <= 1'b1;
				dl_vld_q[wr_addr]  <= 1'b1;
			end
			// drop every deadline at once
			if (ctl.clr_dl) begin
				dl_vld_q <= '0;
			end
			if (ctl.rd_en) begin
				rd_ent_vld_q <= ent_vld_q[rd_addr];
				rd_dl_vld_q  <= ent_vld_q[rd_addr] & dl_vld_q[rd_addr];
			end
		end
	end

	always_comb begin
		rd_data          = rd_raw_q;
		rd_data.start    = rd_ent_vld_q ? rd_raw_q.start : '0;
		rd_data.deadline = rd_dl_vld_q ? rd_raw_q.deadline : '0;
	end

endmodule

`default_nettype wire

@@ rtl/ptsb_checker.sv @@
// ----------------------------------------------------------------------------
// ptsb_checker
// Port-level checks of the timer slot bank command and result timing.
// ----------------------------------------------------------------------------
`default_nettype none

module ptsb_checker (
	input wire clk,
	input wire arst_n,
	input wire start,
	input wire busy,
	input wire done,
	input wire expired
);

	// an accepted word either keeps the block busy or completes at once
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted word neither busy nor done");

	// expired is only meaningful with the strobe
	a_expired_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		expired |-> done)
		else $error("expired without done");

	// a result is never shown while a word is still at work
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	// a result follows an accept or a busy cycle
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy || start))
		else $error("done without a word in flight");

endmodule

bind periodic_timer_slot_bank ptsb_checker u_ptsb_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.done    (done),
	.expired (expired)
);

`default_nettype wire

@@ dv/periodic_timer_slot_bank_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// periodic_timer_slot_bank_tb
// Self-checking bench for the timer slot bank: words are driven through the
// start/busy handshake, a cycle-free predictor of ticks, arms and queries
// computes the expired flag of each word, and every done strobe is checked
// against the oldest prediction. A directed sequence is followed by random
// words in four phases of sender idling.
// ----------------------------------------------------------------------------

module periodic_timer_slot_bank_tb;

	localparam int SLOTS = 16;
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int TIMEOUT_NS = 5_000_000;
	localparam int DRAIN_CYCLES = 2 * SLOTS + 8;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  kind;
	logic [3:0]  slot;
	logic [15:0] period;
	logic        done;
	logic        expired;
	int          idle_pct;

	class expiry_predictor;
		bit [31:0] tick_count;
		bit [31:0] wrap_limit;
		bit        overflow;
		bit [31:0] start_at [SLOTS];
		bit [31:0] deadline [SLOTS];
		bit [15:0] period_of [SLOTS];
		bit        armed [SLOTS];
		bit        expected_expiry [$];
		int        mismatches;

		function new();
			tick_count = '0;
			wrap_limit = '0;
			overflow = 1'b0;
			mismatches = 0;
			foreach (armed[i]) begin
				start_at[i] = '0;
				deadline[i] = '0;
				period_of[i] = '0;
				armed[i] = 1'b0;
			end
		endfunction

		function void arm(int s, bit [15:0] p);
			start_at[s] = tick_count;
			period_of[s] = p;
			armed[s] = 1'b1;
			deadline[s] = tick_count + {16'h0000, p};
			if (!overflow && wrap_limit <= deadline[s])
				wrap_limit = deadline[s];
		endfunction

		function void note_word(logic [1:0] k, logic [3:0] s, logic [15:0] p);
			bit hit;
			hit = 1'b0;
			if (k == ptsb_pkg::KIND_TICK) begin
				tick_count = tick_count + 32'd1;
				if (!overflow) begin
					if (tick_count >= ptsb_pkg::WRAP_POINT) begin
						if (tick_count >= wrap_limit) begin
							tick_count = '0;
							foreach (deadline[i])
								deadline[i] = '0;
						end else begin
							overflow = 1'b1;
							wrap_limit = wrap_limit - ptsb_pkg::WRAP_POINT;
						end
					end
				end else begin
					wrap_limit = wrap_limit - 32'd1;
					if (wrap_limit == 0) begin
						// rebase every slot, armed or not
						tick_count = '0;
						overflow = 1'b0;
						foreach (deadline[i])
							deadline[i] = deadline[i] - start_at[i];
					end
				end
			end else if (k == ptsb_pkg::KIND_ARM && int'(s) < SLOTS) begin
				arm(int'(s), p);
			end else if (k == ptsb_pkg::KIND_QUERY && int'(s) < SLOTS) begin
				start_at[s] = tick_count;
				if (armed[s] && start_at[s] >= deadline[s]) begin
					arm(int'(s), period_of[s]);
					hit = 1'b1;
				end
			end
			expected_expiry.push_back(hit);
		endfunction

		function void check_expiry(logic got);
			bit want;
			if (expected_expiry.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with no word outstanding, expired=%b", $time, got);
				return;
			end
			want = expected_expiry.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: expired mismatch: expected %0b, got %b", $time, want, got);
			end
		endfunction
	endclass

	expiry_predictor pred;

	periodic_timer_slot_bank #(.NUM_SLOTS(SLOTS)) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.kind    (kind),
		.slot    (slot),
		.period  (period),
		.done    (done),
		.expired (expired)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("FAILURE");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && done === 1'b1)
			pred.check_expiry(expired);
	end

	// Enter and leave at a falling edge; the word is taken when busy is low.
	task automatic send_word(input logic [1:0] k, input logic [3:0] s, input logic [15:0] p);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct)
			repeat ($urandom_range(4, 1)) @(negedge clk);
		start = 1'b1;
		kind = k;
		slot = s;
		period = p;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		pred.note_word(k, s, p);
		@(negedge clk);
		start = 1'b0;
	endtask

	task automatic send_random_word(input int tick_weight);
		int r;
		logic [3:0] s;
		logic [15:0] p;
		logic [1:0] k;
		r = $urandom_range(99);
		s = 4'($urandom_range(15));
		case ($urandom_range(3))
			0: p = 16'($urandom_range(15));
			1: p = 16'($urandom_range(255));
			2: p = 16'($urandom());
			default: p = $urandom_range(1) ? 16'hFFFF : 16'h0000;
		endcase
		if (r < tick_weight)
			k = ptsb_pkg::KIND_TICK;
		else if (r < tick_weight + (97 - tick_weight) / 2)
			k = ptsb_pkg::KIND_QUERY;
		else if (r < 97)
			k = ptsb_pkg::KIND_ARM;
		else
			k = KIND_UNUSED;
		send_word(k, s, p);
	endtask

	initial begin
		int phase_idle [4];
		pred = new();
		arst_n = 1'b0;
		start = 1'b0;
		kind = ptsb_pkg::KIND_TICK;
		slot = '0;
		period = '0;
		idle_pct = 0;
		phase_idle = '{0, 65, 12, 0};
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// directed: unarmed query, period extremes, zero period, expiry and rearm
		send_word(ptsb_pkg::KIND_QUERY, 4'd3, 16'h0000);
		send_word(ptsb_pkg::KIND_ARM, 4'd0, 16'hFFFF);
		send_word(ptsb_pkg::KIND_ARM, 4'd15, 16'h0000);
		send_word(ptsb_pkg::KIND_QUERY, 4'd15, 16'h0000);
		send_word(ptsb_pkg::KIND_QUERY, 4'd15, 16'hFFFF);
		send_word(ptsb_pkg::KIND_ARM, 4'd5, 16'h0002);
		send_word(ptsb_pkg::KIND_QUERY, 4'd5, 16'h0000);
		send_word(ptsb_pkg::KIND_TICK, 4'd0, 16'h0000);
		send_word(ptsb_pkg::KIND_TICK, 4'd15, 16'hFFFF);
		send_word(ptsb_pkg::KIND_QUERY, 4'd5, 16'h0000);
		send_word(ptsb_pkg::KIND_QUERY, 4'd5, 16'h0000);
		send_word(KIND_UNUSED, 4'd5, 16'hFFFF);
		send_word(ptsb_pkg::KIND_QUERY, 4'd0, 16'h0000);
		send_word(ptsb_pkg::KIND_ARM, 4'd10, 16'hAAAA);
		send_word(ptsb_pkg::KIND_ARM, 4'd6, 16'h5555);
		send_word(ptsb_pkg::KIND_ARM, 4'd9, 16'h0001);
		send_word(ptsb_pkg::KIND_TICK, 4'd10, 16'h5555);
		send_word(ptsb_pkg::KIND_QUERY, 4'd9, 16'h0000);
		send_word(ptsb_pkg::KIND_TICK, 4'd5, 16'hAAAA);
		send_word(ptsb_pkg::KIND_QUERY, 4'd3, 16'h0000);
		send_word(ptsb_pkg::KIND_QUERY, 4'd6, 16'h0000);

		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = phase_idle[ph];
			repeat (500) send_random_word(50);
		end

		while (pred.expected_expiry.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pred.mismatches == 0 && pred.expected_expiry.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
